[hw/rtl/olad_pkg.sv]
// Shared types and constants for the ordered list with append, remove and indexed read.
`default_nettype none
package olad_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 5;
  localparam int WORD_W = 32;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [1:0]       opcode;
    word_t            value;
    logic [POS_W-1:0] position;
  } in_t;

  typedef struct packed {
    word_t            read_data;
    logic             success;
    logic [LEN_W-1:0] length;
  } out_t;

  typedef struct packed {
    logic live;
    logic load;
    logic shift_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/olad_cell.sv]
// One list slot: holds an entry, matches it and takes its right neighbor's entry on removal.
`default_nettype none
module olad_cell (
  input  wire logic               clk,
  input  wire olad_pkg::cell_ctrl_t ctrl,
  input  wire olad_pkg::word_t    value,
  input  wire olad_pkg::word_t    right_data,
  input  wire logic               seen_in,
  output logic                    seen_out,
  output olad_pkg::word_t         data
);
  import olad_pkg::*;

  word_t data_r;
  word_t data_nxt;

  // seen_out: first match lies at or before this slot
  assign seen_out = seen_in | (ctrl.live & (data_r == value));
  assign data     = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = value;
    end else if (ctrl.shift_en && seen_out) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/ordered_list_append_delete_index.sv]
// Ordered list of signed words with append, remove-first-match and indexed read.
// Each result beat is registered and appears in the cycle after its input beat.
// One command per cycle unless stalled; the slot match ripple is combinational.
// A registered result stage separates the sides; input stalls only while it is held.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
`default_nettype none
module ordered_list_append_delete_index (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire olad_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output olad_pkg::out_t     out_data
);
  import olad_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_data_r;
  out_t             out_data_nxt;

  logic             in_fire;
  logic             not_full;
  logic             append_ok;
  logic             remove_ok;
  logic             read_ok;
  logic             found;
  logic [DEPTH:0]   seen;
  word_t            cell_data [DEPTH];
  cell_ctrl_t       ctrl [DEPTH];

  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign seen[0]   = 1'b0;
  assign found     = seen[DEPTH];
  assign not_full  = (count_r < CNT_W'(DEPTH));
  assign append_ok = (in_data.opcode == OP_APPEND) & not_full;
  assign remove_ok = (in_data.opcode == OP_REMOVE) & found;
  assign read_ok   = (in_data.opcode == OP_READ) &
                     (CMP_W'(in_data.position) < CMP_W'(count_r));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctrl[i].live     = (count_r > CNT_W'(i));
      ctrl[i].load     = in_fire & append_ok & (count_r == CNT_W'(i));
      ctrl[i].shift_en = in_fire & remove_ok;
    end

    olad_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .value      (in_data.value),
      .right_data ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i + 1) % DEPTH]),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    case (in_data.opcode)
      OP_APPEND: if (append_ok) count_nxt = count_r + CNT_W'(1);
      OP_REMOVE: if (remove_ok) count_nxt = count_r - CNT_W'(1);
      default:   count_nxt = count_r;
    endcase

    out_data_nxt.read_data = '0;
    out_data_nxt.success   = 1'b0;
    case (in_data.opcode)
      OP_APPEND: out_data_nxt.success = append_ok;
      OP_REMOVE: out_data_nxt.success = remove_ok;
      OP_READ: begin
        out_data_nxt.success = read_ok;
        if (read_ok) begin
          out_data_nxt.read_data = cell_data[in_data.position[IDX_W-1:0]];
        end
      end
      default:   out_data_nxt.success = 1'b0;
    endcase
    out_data_nxt.length = LEN_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list count exceeds depth");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.opcode == OP_APPEND) && !not_full |=> !out_data_r.success)
    else $error("append to full list reported success");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && remove_ok |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not shrink list");

  a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.opcode == OP_READ) |=> $stable(count_r))
    else $error("read changed list length");

  a_length_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.length == LEN_W'(count_r))
    else $error("result length differs from list count");

endmodule
`default_nettype wire
